FILE: rtl/tasrs_pkg.sv
// Package for the touch ADC SPI read sequencer.
// Holds request and result structs, the phase enum, register indexes and constants.
// No dependencies.
`timescale 1ns / 1ps

package tasrs_pkg;

  localparam int TX_BITS   = 8;
  localparam int RX_BITS   = 16;
  localparam int DROP_BITS = 4;

  localparam int CMD_W     = 8;
  localparam int SAMPLE_W  = 12;
  localparam int TICK_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  localparam int BITS_MAX  = (TX_BITS > RX_BITS) ? TX_BITS : RX_BITS;
  localparam int BIT_CNT_W = $clog2(BITS_MAX + 1);

  localparam logic [TICK_W-1:0] HALF_RESET = TICK_W'(1);
  localparam logic [TICK_W-1:0] WAIT_RESET = TICK_W'(6);

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CONV_WAIT   = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TX_LO = 3'd1,
    PH_TX_HI = 3'd2,
    PH_WAIT  = 3'd3,
    PH_BZ_LO = 3'd4,
    PH_BZ_HI = 3'd5,
    PH_RX_LO = 3'd6,
    PH_RX_HI = 3'd7
  } phase_t;

  typedef struct packed {
    logic             start_req;
    logic [CMD_W-1:0] cmd_byte;
    logic             miso_pin;
  } in_req_t;

  typedef struct packed {
    logic                sclk_pin;
    logic                mosi_pin;
    logic                cs_n_pin;
    logic                busy_res;
    logic                sample_valid;
    logic [SAMPLE_W-1:0] sample;
  } out_res_t;

endpackage

FILE: rtl/touch_adc_spi_read_sequencer.sv
// Touch ADC SPI read sequencer: pin-level SPI master, one request per timing tick.
// Shifts a command out, waits for conversion, clocks in a sample.
// Depends on tasrs_pkg.
// A result is registered in the cycle after its request is accepted.
// Throughput: one request per cycle while in_stall is low; the sequencer state advances once per request.
// The output register and a stall pass-through decouple the two channels.
// Reset (rst_n low, synchronous): phase idle, clock low, data low, chip select high,
// half period 1 tick, conversion wait 6 ticks, no result pending.
`timescale 1ns / 1ps

module touch_adc_spi_read_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tasrs_pkg::in_req_t            in_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tasrs_pkg::out_res_t           out_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tasrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tasrs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tasrs_pkg::*;

  logic [TICK_W-1:0]    half_r, wait_r;
  phase_t               phase_r, phase_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [TICK_W-1:0]    tick_r, tick_nxt;
  logic [TX_BITS-1:0]   tx_r, tx_nxt;
  logic [RX_BITS-1:0]   rx_r, rx_nxt;
  logic                 clk_lvl_r, clk_lvl_nxt;
  logic                 data_lvl_r, data_lvl_nxt;
  logic                 cs_lvl_r, cs_lvl_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_res_t             out_res_r, out_res_nxt;

  logic                 in_take;
  logic [TICK_W-1:0]    half_eff, limit;
  logic [BIT_CNT_W-1:0] bit_inc;
  logic [RX_BITS-1:0]   rx_shifted;
  logic                 done;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_take   = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign half_eff   = (half_r == '0) ? HALF_RESET : half_r;
  assign limit      = (phase_r == PH_WAIT) ? wait_r : half_eff;
  assign bit_inc    = bit_cnt_r + BIT_CNT_W'(1);
  assign rx_shifted = {rx_r[RX_BITS-2:0], in_req.miso_pin};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= HALF_RESET;
      wait_r <= WAIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HALF_PERIOD: half_r <= cfg_data;
        CFG_CONV_WAIT:   wait_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_cnt_r   <= '0;
      tick_r      <= '0;
      tx_r        <= '0;
      rx_r        <= '0;
      clk_lvl_r   <= 1'b0;
      data_lvl_r  <= 1'b0;
      cs_lvl_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      tick_r      <= tick_nxt;
      tx_r        <= tx_nxt;
      rx_r        <= rx_nxt;
      clk_lvl_r   <= clk_lvl_nxt;
      data_lvl_r  <= data_lvl_nxt;
      cs_lvl_r    <= cs_lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_res_r <= out_res_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    tick_nxt     = tick_r;
    tx_nxt       = tx_r;
    rx_nxt       = rx_r;
    clk_lvl_nxt  = clk_lvl_r;
    data_lvl_nxt = data_lvl_r;
    cs_lvl_nxt   = cs_lvl_r;
    done         = 1'b0;

    if (in_take) begin
      if (phase_r == PH_IDLE) begin
        if (in_req.start_req) begin
          tx_nxt       = TX_BITS'(in_req.cmd_byte);
          bit_cnt_nxt  = '0;
          tick_nxt     = TICK_W'(1);
          clk_lvl_nxt  = 1'b0;
          cs_lvl_nxt   = 1'b0;
          data_lvl_nxt = tx_nxt[TX_BITS-1];
          phase_nxt    = PH_TX_LO;
        end
      end else if (tick_r < limit) begin
        tick_nxt = tick_r + TICK_W'(1);
      end else begin
        tick_nxt = TICK_W'(1);
        unique case (phase_r)
          PH_TX_LO: begin
            clk_lvl_nxt = 1'b1;
            phase_nxt   = PH_TX_HI;
          end
          PH_TX_HI: begin
            if (bit_inc >= BIT_CNT_W'(TX_BITS)) begin
              bit_cnt_nxt = '0;
              if (wait_r != '0) begin
                phase_nxt = PH_WAIT;
              end else begin
                clk_lvl_nxt = 1'b0;
                phase_nxt   = PH_BZ_LO;
              end
            end else begin
              bit_cnt_nxt  = bit_inc;
              tx_nxt       = {tx_r[TX_BITS-2:0], 1'b0};
              data_lvl_nxt = tx_r[TX_BITS-2];
              clk_lvl_nxt  = 1'b0;
              phase_nxt    = PH_TX_LO;
            end
          end
          PH_WAIT: begin
            clk_lvl_nxt = 1'b0;
            phase_nxt   = PH_BZ_LO;
          end
          PH_BZ_LO: begin
            clk_lvl_nxt = 1'b1;
            phase_nxt   = PH_BZ_HI;
          end
          PH_BZ_HI: begin
            clk_lvl_nxt = 1'b0;
            rx_nxt      = '0;
            bit_cnt_nxt = '0;
            phase_nxt   = PH_RX_LO;
          end
          PH_RX_LO: begin
            clk_lvl_nxt = 1'b1;
            phase_nxt   = PH_RX_HI;
          end
          PH_RX_HI: begin
            rx_nxt = rx_shifted;
            if (bit_inc >= BIT_CNT_W'(RX_BITS)) begin
              bit_cnt_nxt  = '0;
              tick_nxt     = '0;
              clk_lvl_nxt  = 1'b0;
              data_lvl_nxt = 1'b0;
              cs_lvl_nxt   = 1'b1;
              phase_nxt    = PH_IDLE;
              done         = 1'b1;
            end else begin
              bit_cnt_nxt = bit_inc;
              clk_lvl_nxt = 1'b0;
              phase_nxt   = PH_RX_LO;
            end
          end
          default: ;
        endcase
      end
    end

    out_res_nxt.sclk_pin     = clk_lvl_nxt;
    out_res_nxt.mosi_pin     = data_lvl_nxt;
    out_res_nxt.cs_n_pin     = cs_lvl_nxt;
    out_res_nxt.busy_res     = (phase_nxt != PH_IDLE);
    out_res_nxt.sample_valid = done;
    out_res_nxt.sample       = done ? SAMPLE_W'(rx_shifted >> DROP_BITS) : '0;

    priority if (in_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.sample_valid |-> out_res_r.cs_n_pin && !out_res_r.busy_res
      && !out_res_r.sclk_pin)
    else $error("completion result without released bus");

  a_cs_follows_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) == !cs_lvl_r)
    else $error("chip select out of step with phase");

  a_start_enters_tx: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_req.start_req && phase_r == PH_IDLE |=> phase_r == PH_TX_LO
      && out_valid_r && out_res_r.busy_res)
    else $error("accepted start did not begin command phase");

  a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> tick_r == '0 && bit_cnt_r == '0)
    else $error("counters not cleared in idle");

endmodule
